>>> rtl/wwm_pkg.sv
// Shared types and constants for the windowed weighted moments block.
// No dependencies; every other file in rtl/ uses these by scoped names.

package wwm_pkg;

   // Field widths
   localparam int POS_W    = 32;
   localparam int WEIGHT_W = 16;
   localparam int WIDTH_W  = 16;
   localparam int TOTAL_W  = 32;
   localparam int MOM_W    = 40;
   localparam int FRAC_W   = 8;

   // Running sums
   localparam int S1_W = 50;
   localparam int S2_W = 64;

   // Shared arithmetic units
   localparam int MUL_W      = 32;
   localparam int ACC_W      = 104;
   localparam int DIVIDEND_W = 104;
   localparam int DIVISOR_W  = 64;

   // Parameter defaults and reset values
   localparam int MAX_POINTS_DEFAULT  = 65536;
   localparam int WEIGHT_BITS_DEFAULT = 16;
   localparam logic [WIDTH_W-1:0] WINDOW_WIDTH_RESET = 16'd1024;

   // Operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [POS_W-1:0]    position;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_weight;
      logic [MOM_W-1:0]   mean_position;
      logic [MOM_W-1:0]   position_variance;
      logic               zero_weight;
      logic               overflow;
   } rsp_type;

endpackage

>>> rtl/wwm_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on wwm_pkg for the operand width.

module wwm_mul (
   input  logic                         clock,
   input  logic [wwm_pkg::MUL_W-1:0]    operand_a,
   input  logic [wwm_pkg::MUL_W-1:0]    operand_b,
   output logic [2*wwm_pkg::MUL_W-1:0]  product
);

   logic [2*wwm_pkg::MUL_W-1:0] product_ff;
   logic [2*wwm_pkg::MUL_W-1:0] product_in;

   always_comb begin
      product_in = (2*wwm_pkg::MUL_W)'(operand_a) * (2*wwm_pkg::MUL_W)'(operand_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

>>> rtl/wwm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wwm_pkg for its default widths.

module wwm_div #(
   parameter int DIVIDEND_W = wwm_pkg::DIVIDEND_W,
   parameter int DIVISOR_W  = wwm_pkg::DIVISOR_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dnd_ff, dnd_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, dnd_ff[DIVIDEND_W-1]};
      fits      = rem_shift >= {1'b0, dsr_ff};
      rem_diff  = rem_shift - {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      dnd_in  = dnd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;

      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         dnd_in  = dividend;
         dsr_in  = divisor;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits back in DIVISOR_W bits.
         rem_in = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         dnd_in = {dnd_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dnd_ff <= dnd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/windowed_weighted_moments_core.sv
// Windowed weighted moments core (depends on wwm_pkg, wwm_mul and wwm_div). Weighted events
// are grouped into windows that open at the first event's position; an event more than
// window_width ticks away from the window start, or a flush, closes the window and produces
// one result with the total weight, the weighted mean position and the weighted variance,
// both in unsigned fixed point with 8 fraction bits. The block works on one item at a time
// and drops req_ready while busy. All arithmetic runs through one registered 32 x 32
// multiplier and one bit-serial divider under a one-hot sequencer. An added point that stays
// in the open window takes three multiplier passes before the next item can be taken. Closing
// a window runs six more multiplier passes, from ST_E_SW0 to ST_E_WW, to form W*S2 - S1^2
// and W^2, then two 104-step divisions (variance, then mean), one bit per cycle; ST_E_MEAN
// then clamps the mean and ST_OUT loads the result. A window with zero total weight skips
// both divisions, and a negative variance numerator skips the first. When the closing item
// is a point, it is then added to a fresh window. The result sits in an output register,
// so the block only waits on rsp_ready when a second result is due before the first has
// been taken.

module windowed_weighted_moments_core #(
   parameter int MAX_POINTS  = wwm_pkg::MAX_POINTS_DEFAULT,
   parameter int WEIGHT_BITS = wwm_pkg::WEIGHT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  wwm_pkg::req_type              req_data,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wwm_pkg::rsp_type              rsp_data,

   input  logic                          csr_write_en,
   input  logic [wwm_pkg::WIDTH_W-1:0]   csr_write_data
);

   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int POS_W    = wwm_pkg::POS_W;
   localparam int WEIGHT_W = wwm_pkg::WEIGHT_W;
   localparam int TOTAL_W  = wwm_pkg::TOTAL_W;
   localparam int MOM_W    = wwm_pkg::MOM_W;
   localparam int FRAC_W   = wwm_pkg::FRAC_W;
   localparam int S1_W     = wwm_pkg::S1_W;
   localparam int S2_W     = wwm_pkg::S2_W;
   localparam int MUL_W    = wwm_pkg::MUL_W;
   localparam int ACC_W    = wwm_pkg::ACC_W;
   localparam int DND_W    = wwm_pkg::DIVIDEND_W;
   localparam int DSR_W    = wwm_pkg::DIVISOR_W;
   localparam int OFS_W    = wwm_pkg::WIDTH_W;
   // Mean quotient bits and the signed width of start*256 plus or minus that quotient.
   localparam int QM_W     = S1_W + FRAC_W;
   localparam int MSUM_W   = QM_W + 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = {WEIGHT_W{1'b1}} >> (WEIGHT_W - WEIGHT_BITS);
   localparam logic [S1_W-1:0] S1_MAX = {1'b0, {(S1_W-1){1'b1}}};
   localparam logic [S1_W-1:0] S1_MIN = {1'b1, {(S1_W-1){1'b0}}};

   // Sequencer states: P_* add a point, E_* close a window.
   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_CHECK  = 17'h00002,
      ST_P_TERM = 17'h00004,
      ST_P_SQ   = 17'h00008,
      ST_P_SQW  = 17'h00010,
      ST_P_ACC  = 17'h00020,
      ST_E_SW0  = 17'h00040,
      ST_E_SW1  = 17'h00080,
      ST_E_MM00 = 17'h00100,
      ST_E_MM01 = 17'h00200,
      ST_E_MM11 = 17'h00400,
      ST_E_WW   = 17'h00800,
      ST_E_WWL  = 17'h01000,
      ST_E_DIVV = 17'h02000,
      ST_E_DIVM = 17'h04000,
      ST_E_MEAN = 17'h08000,
      ST_OUT    = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // Control state and running sums
   logic [OFS_W-1:0]    width_ff, width_in;
   logic                open_ff, open_in;
   logic [TOTAL_W-1:0]  wsum_ff, wsum_in;
   logic [S1_W-1:0]     s1_ff, s1_in;
   logic [S2_W-1:0]     s2_ff, s2_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic                item_op_ff, item_op_in;
   logic [POS_W-1:0]    item_pos_ff, item_pos_in;
   logic [WEIGHT_W-1:0] item_wt_ff, item_wt_in;
   logic [POS_W-1:0]    start_ff, start_in;
   logic [OFS_W-1:0]    aofs_ff, aofs_in;
   logic                neg_ff, neg_in;
   logic [S1_W-1:0]     mag_ff, mag_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [MOM_W-1:0]    mean_ff, mean_in;
   logic [MOM_W-1:0]    var_ff, var_in;
   wwm_pkg::rsp_type    rsp_ff, rsp_in;

   // Shared units
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [2*MUL_W-1:0]  product;
   logic                div_start, div_done;
   logic [DND_W-1:0]    div_dividend, div_quo;
   logic [DSR_W-1:0]    div_divisor, div_rem;

   // Datapath intermediates
   logic [POS_W:0]      diff;
   logic [POS_W:0]      span;
   logic                too_far;
   logic [S1_W:0]       s1_sum;
   logic [S2_W:0]       s2_sum;
   logic [TOTAL_W:0]    wsum_sum;
   logic [QM_W-1:0]     q_mag;
   logic [MSUM_W-1:0]   m_base, m_sum;
   logic [ACC_W-1:0]    pp_shift32, pp_shift33, pp_shift64;

   wwm_mul u_mul (
      .clock     (clock),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product)
   );

   wwm_div #(
      .DIVIDEND_W (DND_W),
      .DIVISOR_W  (DSR_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      // Distance of the current point from the window start, as a magnitude.
      diff    = {1'b0, item_pos_ff} - {1'b0, start_ff};
      span    = diff[POS_W] ? (~diff + (POS_W+1)'(1)) : diff;
      too_far = span > (POS_W+1)'(width_ff);

      // Signed offset sum plus or minus the current term; one extra bit catches overflow.
      s1_sum = neg_ff ? ({s1_ff[S1_W-1], s1_ff} - (S1_W+1)'(product[MUL_W-1:0]))
                      : ({s1_ff[S1_W-1], s1_ff} + (S1_W+1)'(product[MUL_W-1:0]));
      s2_sum   = {1'b0, s2_ff} + (S2_W+1)'(product);
      wsum_sum = {1'b0, wsum_ff} + (TOTAL_W+1)'(item_wt_ff);

      // Partial products placed for W*S2 - S1^2.
      pp_shift32 = ACC_W'(product) << 32;
      pp_shift33 = ACC_W'(product) << 33;
      pp_shift64 = ACC_W'(product) << 64;

      // Signed mean quotient rounds toward minus infinity: a negative sum rounds its
      // magnitude up whenever the division leaves a remainder.
      q_mag  = div_quo[QM_W-1:0] + QM_W'(s1_ff[S1_W-1] && (div_rem != '0));
      m_base = MSUM_W'({start_ff, {FRAC_W{1'b0}}});
      m_sum  = s1_ff[S1_W-1] ? (m_base - MSUM_W'(q_mag)) : (m_base + MSUM_W'(q_mag));
   end

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      open_in      = open_ff;
      wsum_in      = wsum_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      item_op_in   = item_op_ff;
      item_pos_in  = item_pos_ff;
      item_wt_in   = item_wt_ff;
      start_in     = start_ff;
      aofs_in      = aofs_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      rsp_in       = rsp_ff;

      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      // The mean division is the default load; only the variance start overrides it.
      div_dividend = DND_W'({mag_ff, {FRAC_W{1'b0}}});
      div_divisor  = DSR_W'(wsum_ff);

      if (csr_write_en) begin
         width_in = csr_write_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_op_in  = req_data.operation;
               item_pos_in = req_data.position;
               item_wt_in  = req_data.weight & WEIGHT_MASK;
               state_in    = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (item_op_ff == wwm_pkg::OP_FLUSH) begin
               // A flush with no open window produces nothing.
               state_in = open_ff ? ST_E_SW0 : ST_IDLE;
            end else if (!open_ff) begin
               open_in  = 1'b1;
               start_in = item_pos_ff;
               aofs_in  = '0;
               neg_in   = 1'b0;
               state_in = ST_P_TERM;
            end else if (too_far) begin
               state_in = ST_E_SW0;
            end else begin
               // Inside the window the offset is bounded by the 16-bit window width.
               aofs_in  = span[OFS_W-1:0];
               neg_in   = diff[POS_W];
               state_in = ST_P_TERM;
            end
         end

         ST_P_TERM: begin
            mul_a    = MUL_W'(aofs_ff);
            mul_b    = MUL_W'(item_wt_ff);
            state_in = ST_P_SQ;
         end

         ST_P_SQ: begin
            mul_a = MUL_W'(aofs_ff);
            mul_b = MUL_W'(aofs_ff);
            if (s1_sum[S1_W] != s1_sum[S1_W-1]) begin
               s1_in  = s1_sum[S1_W] ? S1_MIN : S1_MAX;
               ovf_in = 1'b1;
            end else begin
               s1_in = s1_sum[S1_W-1:0];
            end
            state_in = ST_P_SQW;
         end

         ST_P_SQW: begin
            mul_a    = product[MUL_W-1:0];
            mul_b    = MUL_W'(item_wt_ff);
            state_in = ST_P_ACC;
         end

         ST_P_ACC: begin
            if (s2_sum[S2_W]) begin
               s2_in  = '1;
               ovf_in = 1'b1;
            end else begin
               s2_in = s2_sum[S2_W-1:0];
            end
            if (wsum_sum[TOTAL_W]) begin
               wsum_in = '1;
               ovf_in  = 1'b1;
            end else begin
               wsum_in = wsum_sum[TOTAL_W-1:0];
            end
            if (cnt_ff >= CNT_W'(MAX_POINTS)) begin
               ovf_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end

         ST_E_SW0: begin
            mul_a    = s2_ff[MUL_W-1:0];
            mul_b    = wsum_ff;
            mag_in   = s1_ff[S1_W-1] ? (~s1_ff + S1_W'(1)) : s1_ff;
            state_in = ST_E_SW1;
         end

         ST_E_SW1: begin
            mul_a    = s2_ff[S2_W-1:MUL_W];
            mul_b    = wsum_ff;
            acc_in   = ACC_W'(product);
            state_in = ST_E_MM00;
         end

         ST_E_MM00: begin
            mul_a    = mag_ff[MUL_W-1:0];
            mul_b    = mag_ff[MUL_W-1:0];
            acc_in   = acc_ff + pp_shift32;
            state_in = ST_E_MM01;
         end

         ST_E_MM01: begin
            mul_a    = mag_ff[MUL_W-1:0];
            mul_b    = MUL_W'(mag_ff[S1_W-1:MUL_W]);
            acc_in   = acc_ff - ACC_W'(product);
            state_in = ST_E_MM11;
         end

         ST_E_MM11: begin
            mul_a    = MUL_W'(mag_ff[S1_W-1:MUL_W]);
            mul_b    = MUL_W'(mag_ff[S1_W-1:MUL_W]);
            // The cross term appears twice in the square.
            acc_in   = acc_ff - pp_shift33;
            state_in = ST_E_WW;
         end

         ST_E_WW: begin
            mul_a    = wsum_ff;
            mul_b    = wsum_ff;
            acc_in   = acc_ff - pp_shift64;
            state_in = ST_E_WWL;
         end

         ST_E_WWL: begin
            if (wsum_ff == '0) begin
               mean_in  = {start_ff, {FRAC_W{1'b0}}};
               var_in   = '0;
               state_in = ST_OUT;
            end else if (acc_ff[ACC_W-1]) begin
               // A negative variance numerator reads as zero.
               var_in    = '0;
               div_start = 1'b1;
               state_in  = ST_E_DIVM;
            end else begin
               div_start    = 1'b1;
               div_dividend = {acc_ff[DND_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
               div_divisor  = product;
               state_in     = ST_E_DIVV;
            end
         end

         ST_E_DIVV: begin
            if (div_done) begin
               var_in    = (div_quo[DND_W-1:MOM_W] != '0) ? '1 : div_quo[MOM_W-1:0];
               div_start = 1'b1;
               state_in  = ST_E_DIVM;
            end
         end

         ST_E_DIVM: begin
            if (div_done) begin
               state_in = ST_E_MEAN;
            end
         end

         ST_E_MEAN: begin
            if (m_sum[MSUM_W-1]) begin
               mean_in = '0;
            end else if (m_sum[MSUM_W-2:MOM_W] != '0) begin
               mean_in = '1;
            end else begin
               mean_in = m_sum[MOM_W-1:0];
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.total_weight      = wsum_ff;
               rsp_in.mean_position     = mean_ff;
               rsp_in.position_variance = var_ff;
               rsp_in.zero_weight       = (wsum_ff == '0);
               rsp_in.overflow          = ovf_ff;
               rsp_valid_in             = 1'b1;
               open_in                  = 1'b0;
               wsum_in                  = '0;
               s1_in                    = '0;
               s2_in                    = '0;
               cnt_in                   = '0;
               ovf_in                   = 1'b0;
               // A point that closed the window now opens the next one.
               state_in = (item_op_ff == wwm_pkg::OP_ADD) ? ST_CHECK : ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= wwm_pkg::WINDOW_WIDTH_RESET;
         open_ff      <= 1'b0;
         wsum_ff      <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         open_ff      <= open_in;
         wsum_ff      <= wsum_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_op_ff  <= item_op_in;
      item_pos_ff <= item_pos_in;
      item_wt_ff  <= item_wt_in;
      start_ff    <= start_in;
      aofs_ff     <= aofs_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for windowed_weighted_moments_core: directed and random weighted events
// run through the core, and every closed-window result is checked against an in-bench model.
// Depends only on the package wwm_pkg and the core module.

module testbench;

   localparam int     POS_W              = wwm_pkg::POS_W;
   localparam int     WEIGHT_W           = wwm_pkg::WEIGHT_W;
   localparam int     WIDTH_W            = wwm_pkg::WIDTH_W;
   localparam int     TOTAL_W            = wwm_pkg::TOTAL_W;
   localparam int     MOM_W              = wwm_pkg::MOM_W;
   localparam int     FRAC_W             = wwm_pkg::FRAC_W;
   localparam int     S2_W               = wwm_pkg::S2_W;
   localparam int     HALF_PERIOD        = 2;
   localparam int     MAX_POINTS         = wwm_pkg::MAX_POINTS_DEFAULT;
   localparam int     WEIGHT_BITS        = wwm_pkg::WEIGHT_BITS_DEFAULT;
   // Long enough for the core to finish one more close.
   localparam int     CLOSE_CYCLES       = 300;
   localparam int     HOLD_CYCLES        = 1500;
   localparam int     RANDOM_PER_SETTING = 205;
   localparam int     QUEUE_DEPTH        = 256;
   localparam int     MISMATCH_REPORTS   = 10;
   localparam longint CYCLE_LIMIT        = 4000000;
   localparam longint OFFSET_SUM_MAX     = (longint'(1) <<< 49) - 1;
   localparam longint OFFSET_SUM_MIN     = -OFFSET_SUM_MAX - 1;
   localparam logic [MOM_W-1:0] MOMENT_MAX = '1;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   wwm_pkg::req_type   req_data       = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   wwm_pkg::rsp_type   rsp_data;
   logic               csr_write_en   = 1'b0;
   logic [WIDTH_W-1:0] csr_write_data = wwm_pkg::WINDOW_WIDTH_RESET;

   // Model of the window accumulator. The bit types start at zero, which is the reset state.
   bit                 win_open;
   bit [POS_W-1:0]     win_start;
   bit [TOTAL_W-1:0]   sum_weight;
   longint             sum_offset;
   bit [S2_W-1:0]      sum_square;
   int                 point_count;
   bit                 sums_saturated;
   bit [WIDTH_W-1:0]   cfg_window_width = wwm_pkg::WINDOW_WIDTH_RESET;

   // Events waiting for the driver, and window results waiting to come out of the core.
   wwm_pkg::req_type   pending_events[$];
   wwm_pkg::rsp_type   expected_moments[$];

   longint             cycle_count;
   int                 events_queued;
   int                 events_accepted;
   int                 results_checked;
   int                 mismatch_count;
   int                 width_settings;
   bit                 req_taken;
   int                 send_idle_pct = 7;
   int                 rsp_idle_pct  = 54;
   int                 hold_order;
   int                 hold_served;
   int                 hold_left;

   windowed_weighted_moments_core #(
      .MAX_POINTS  (MAX_POINTS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Closes the open window: forms total, mean and variance from the running sums, then
   // clears the sums. The mean offset rounds toward minus infinity, the variance truncates,
   // and both are clamped to the 40-bit output range.
   function automatic wwm_pkg::rsp_type close_window();
      bit [63:0]        total;
      bit [63:0]        magnitude;
      longint           mean_shift;
      longint           mean_fixed;
      bit [127:0]       weighted_square;
      bit [127:0]       offset_square;
      bit [127:0]       spread;
      wwm_pkg::rsp_type result;
      total     = 64'(sum_weight);
      magnitude = (sum_offset < 0) ? 64'(-sum_offset) : 64'(sum_offset);
      result    = '0;
      result.total_weight = sum_weight;
      result.zero_weight  = (sum_weight == '0);
      result.overflow     = sums_saturated;
      if (sum_weight == '0) begin
         // With no weight the mean falls back to the window start and the variance is zero.
         result.mean_position = {win_start, 8'h00};
      end else begin
         if (sum_offset >= 0) begin
            mean_shift = longint'((magnitude << FRAC_W) / total);
         end else begin
            mean_shift = -longint'(((magnitude << FRAC_W) + total - 1) / total);
         end
         mean_fixed = longint'({24'h0, win_start, 8'h00}) + mean_shift;
         if (mean_fixed < 0) begin
            mean_fixed = 0;
         end
         result.mean_position = (mean_fixed > longint'(MOMENT_MAX)) ? MOMENT_MAX
                                                                    : mean_fixed[MOM_W-1:0];
         // Variance is (W*S2 - S1^2) / W^2; a negative numerator, possible only after
         // saturation, leaves it at zero.
         weighted_square = 128'(sum_square) * 128'(total);
         offset_square   = 128'(magnitude) * 128'(magnitude);
         if (weighted_square >= offset_square) begin
            spread = ((weighted_square - offset_square) << FRAC_W)
                     / (128'(total) * 128'(total));
            result.position_variance = (spread > 128'(MOMENT_MAX)) ? MOMENT_MAX
                                                                   : spread[MOM_W-1:0];
         end
      end
      win_open       = 1'b0;
      sum_weight     = '0;
      sum_offset     = 0;
      sum_square     = '0;
      point_count    = 0;
      sums_saturated = 1'b0;
      return result;
   endfunction

   // Adds one point to the window, opening it at this point if none is open. Every sum
   // holds at its limit instead of wrapping, and any such event marks the window.
   function automatic void add_point(bit [POS_W-1:0] position, bit [WEIGHT_W-1:0] weight);
      longint     offset;
      bit [63:0]  distance;
      longint     term;
      bit [32:0]  weight_next;
      bit [127:0] square_next;
      if (!win_open) begin
         win_open  = 1'b1;
         win_start = position;
      end
      offset   = longint'({32'h0, position}) - longint'({32'h0, win_start});
      distance = (offset < 0) ? 64'(-offset) : 64'(offset);
      if (point_count >= MAX_POINTS) begin
         sums_saturated = 1'b1;
      end else begin
         point_count++;
      end
      weight_next = {1'b0, sum_weight} + {17'h0, weight};
      if (weight_next[32]) begin
         sum_weight     = '1;
         sums_saturated = 1'b1;
      end else begin
         sum_weight = weight_next[31:0];
      end
      term = longint'(distance * 64'(weight));
      if (offset < 0) begin
         term = -term;
      end
      if (term > 0 && sum_offset > OFFSET_SUM_MAX - term) begin
         sum_offset     = OFFSET_SUM_MAX;
         sums_saturated = 1'b1;
      end else if (term < 0 && sum_offset < OFFSET_SUM_MIN - term) begin
         sum_offset     = OFFSET_SUM_MIN;
         sums_saturated = 1'b1;
      end else begin
         sum_offset = sum_offset + term;
      end
      square_next = 128'(sum_square) + 128'(distance) * 128'(distance) * 128'(weight);
      if (square_next[127:64] != '0) begin
         sum_square     = '1;
         sums_saturated = 1'b1;
      end else begin
         sum_square = square_next[63:0];
      end
   endfunction

   // Applies one accepted event to the model; returns 1 when it closes a window.
   // A point too far from the window start closes that window first and then opens
   // a new one of its own.
   function automatic bit predict_event(input wwm_pkg::req_type item,
                                        output wwm_pkg::rsp_type result);
      bit [WEIGHT_W-1:0] weight;
      longint            distance;
      bit                closes;
      weight = item.weight & WEIGHT_W'((64'd1 << WEIGHT_BITS) - 1);
      result = '0;
      closes = 1'b0;
      if (item.operation == wwm_pkg::OP_FLUSH) begin
         if (win_open) begin
            result = close_window();
            closes = 1'b1;
         end
      end else begin
         if (win_open) begin
            distance = longint'({32'h0, item.position}) - longint'({32'h0, win_start});
            if (distance < 0) begin
               distance = -distance;
            end
            if (distance > longint'({48'h0, cfg_window_width})) begin
               result = close_window();
               closes = 1'b1;
            end
         end
         add_point(item.position, weight);
      end
      return closes;
   endfunction

   task automatic report_mismatch(string what, wwm_pkg::rsp_type wanted,
                                  wwm_pkg::rsp_type seen);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_REPORTS) begin
         $display("Mismatch at cycle %0d, %s: expected total %0d mean %h var %h zero %b ovf %b",
                  cycle_count, what, wanted.total_weight, wanted.mean_position,
                  wanted.position_variance, wanted.zero_weight, wanted.overflow);
         $display("   got total %0d mean %h var %h zero %b ovf %b", seen.total_weight,
                  seen.mean_position, seen.position_variance, seen.zero_weight, seen.overflow);
      end
   endtask

   // Queues one event for the driver; it keeps the queue short so that long runs of
   // events are produced as they are consumed.
   task automatic queue_event(logic operation, logic [POS_W-1:0] position,
                              logic [WEIGHT_W-1:0] weight);
      wwm_pkg::req_type item;
      while (pending_events.size() >= QUEUE_DEPTH) begin
         @(negedge clock);
      end
      item.operation = operation;
      item.position  = position;
      item.weight    = weight;
      pending_events.insert(pending_events.size(), item);
      events_queued++;
   endtask

   // Waits until every queued event has been taken and every result has come out,
   // then lets one close time pass in case the core still owes a result.
   task automatic wait_until_idle();
      while (events_accepted != events_queued || expected_moments.size() != 0) begin
         @(negedge clock);
      end
      repeat (CLOSE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window_width(int unsigned value);
      wait_until_idle();
      @(negedge clock);
      csr_write_en     <= 1'b1;
      csr_write_data   <= WIDTH_W'(value);
      cfg_window_width  = WIDTH_W'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      width_settings++;
   endtask

   task automatic set_idle(int send_pct, int rsp_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
   endtask

   function automatic logic [WEIGHT_W-1:0] random_weight();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return WEIGHT_W'($urandom_range(1, 15));
         default: return WEIGHT_W'($urandom());
      endcase
   endfunction

   // Window starts lean toward both ends of the position range, where the offsets
   // are clipped on one side.
   function automatic logic [POS_W-1:0] random_base();
      case ($urandom_range(0, 7))
         0: return POS_W'($urandom_range(0, 65535));
         1: return 32'hFFFF_FFFF - POS_W'($urandom_range(0, 65535));
         default: return $urandom();
      endcase
   endfunction

   // One well-formed window: a start point and up to eleven more points around it,
   // sometimes exactly at the width or one tick past it, ended by a flush half the time.
   // Stray flushes and lone far points are mixed in as noise.
   task automatic queue_random_window();
      int unsigned points;
      int unsigned k;
      longint      width;
      longint      base;
      longint      offset;
      longint      position;
      width = longint'(cfg_window_width);
      if ($urandom_range(0, 9) == 0) begin
         queue_event(wwm_pkg::OP_FLUSH, $urandom(), WEIGHT_W'($urandom()));
      end
      if ($urandom_range(0, 14) == 0) begin
         queue_event(wwm_pkg::OP_ADD, $urandom(), random_weight());
      end
      base = longint'(random_base());
      queue_event(wwm_pkg::OP_ADD, POS_W'(base), random_weight());
      points = $urandom_range(1, 12);
      for (k = 1; k < points; k++) begin
         case ($urandom_range(0, 9))
            0: offset = width;
            1: offset = -width;
            2: offset = width + 1;
            default: begin
               offset = $urandom_range(0, int'(width));
               if ($urandom_range(0, 1) == 1) begin
                  offset = -offset;
               end
            end
         endcase
         position = base + offset;
         if (position < 0 || position > longint'(32'hFFFF_FFFF)) begin
            position = base - offset;
         end
         queue_event(wwm_pkg::OP_ADD, POS_W'(position), random_weight());
      end
      if ($urandom_range(0, 9) < 5) begin
         queue_event(wwm_pkg::OP_FLUSH, $urandom(), WEIGHT_W'($urandom()));
      end
   endtask

   // Driver: presents the next queued event at the falling edge once the previous
   // transfer has completed, and holds valid and payload steady until it does.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= pending_events.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off whenever the stimulus asks
   // for one. The hold-off is counted here so it does not depend on the stimulus timing.
   always @(negedge clock) begin
      if (hold_served != hold_order) begin
         hold_served = hold_order;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Monitor: checks each result transfer against the oldest expected window, then runs
   // the model on the event transfer of the same edge. Results always belong to events
   // taken at earlier edges, so the order of the two steps is safe.
   always @(posedge clock) begin
      wwm_pkg::rsp_type predicted;
      wwm_pkg::rsp_type wanted;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_moments.size() == 0) begin
               report_mismatch("result with no window closed", '0, rsp_data);
            end else begin
               wanted = expected_moments.pop_front();
               results_checked++;
               if (rsp_data.total_weight !== wanted.total_weight
                   || rsp_data.mean_position !== wanted.mean_position
                   || rsp_data.position_variance !== wanted.position_variance
                   || rsp_data.zero_weight !== wanted.zero_weight
                   || rsp_data.overflow !== wanted.overflow) begin
                  report_mismatch("wrong window result", wanted, rsp_data);
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            events_accepted++;
            if (predict_event(req_data, predicted)) begin
               expected_moments.insert(expected_moments.size(), predicted);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still outstanding.",
                  cycle_count, expected_moments.size());
         $display("** windowed_weighted_moments_core: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned width_plan[6];
      int          setting;
      int          target;
      width_plan    = '{0, 0, 65535, 0, 1024, 65535};
      width_plan[1] = $urandom_range(1, 4095);
      width_plan[3] = $urandom_range(4096, 65534);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset width of 1024 ticks.
      queue_event(wwm_pkg::OP_FLUSH, 32'h0, 16'h0);             // nothing open: no result
      queue_event(wwm_pkg::OP_ADD,   32'd1000, 16'h0);
      queue_event(wwm_pkg::OP_FLUSH, 32'hFFFF_FFFF, 16'hFFFF);  // zero-weight window
      queue_event(wwm_pkg::OP_ADD,   32'd0, 16'hFFFF);
      queue_event(wwm_pkg::OP_ADD,   32'd1024, 16'd1);          // exactly at the width: stays
      queue_event(wwm_pkg::OP_ADD,   32'd1025, 16'd3);          // one tick past: closes, reopens
      queue_event(wwm_pkg::OP_ADD,   32'd1, 16'd5);             // width below the start: stays
      queue_event(wwm_pkg::OP_ADD,   32'd0, 16'd7);             // one tick further below: closes
      queue_event(wwm_pkg::OP_ADD,   32'hFFFF_FFFF, 16'hFFFF);  // top of the position range
      queue_event(wwm_pkg::OP_ADD,   32'hFFFF_FC01, 16'hFFFF);
      queue_event(wwm_pkg::OP_ADD,   32'hFFFF_FFFE, 16'h5555);
      queue_event(wwm_pkg::OP_FLUSH, 32'h0, 16'h0);
      queue_event(wwm_pkg::OP_FLUSH, 32'h1234_5678, 16'hAAAA);  // already closed: no result
      queue_event(wwm_pkg::OP_ADD,   32'h8000_0000, 16'hAAAA);
      queue_event(wwm_pkg::OP_ADD,   32'h7FFF_FD44, 16'd1);
      queue_event(wwm_pkg::OP_ADD,   32'h8000_0001, 16'h0);
      queue_event(wwm_pkg::OP_FLUSH, 32'h0, 16'h0);
      queue_event(wwm_pkg::OP_ADD,   32'd0, 16'h0);
      queue_event(wwm_pkg::OP_ADD,   32'd5, 16'h0);
      queue_event(wwm_pkg::OP_FLUSH, 32'h0, 16'h0);             // zero weight over two points

      // Random part: six width settings under three stall mixes. Each width write waits
      // until the core is idle, which also gives a sender pause with nothing outstanding.
      for (setting = 0; setting < 6; setting++) begin
         if (setting == 2) begin
            set_idle(54, 7);
         end else if (setting == 4) begin
            set_idle(0, 0);
         end
         write_window_width(width_plan[setting]);
         if (setting == 1) begin
            // The receiver stops for a long stretch while short windows keep closing,
            // so the result register fills and the core has to stall its input.
            hold_order++;
            repeat (12) begin
               queue_event(wwm_pkg::OP_ADD, $urandom(), random_weight());
               queue_event(wwm_pkg::OP_FLUSH, $urandom(), WEIGHT_W'($urandom()));
            end
         end
         target = events_queued + RANDOM_PER_SETTING;
         while (events_queued < target) begin
            queue_random_window();
         end
         queue_event(wwm_pkg::OP_FLUSH, 32'h0, 16'h0);
      end
      wait_until_idle();

      $display("Covered %0d events and %0d window results over %0d width settings,",
               events_accepted, results_checked, width_settings);
      $display("random widths %0d and %0d, three stall mixes and one long hold; %0d mismatches.",
               width_plan[1], width_plan[3], mismatch_count);
      if (mismatch_count == 0 && expected_moments.size() == 0) begin
         $display("** windowed_weighted_moments_core: PASSED **");
      end else begin
         $display("** windowed_weighted_moments_core: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/wwm_pkg.sv
rtl/wwm_mul.sv
rtl/wwm_div.sv
rtl/windowed_weighted_moments_core.sv
test/testbench.sv
